// ===== design/ugns_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ugns_pkg;

  localparam int GRID_DIM_DEF = 16;
  localparam int CELL_CAP_DEF = 4;
  localparam int POS_BITS     = 16;
  localparam int POS_W        = 16;
  localparam int CNT_W        = 3;

  localparam logic [POS_W-1:0] POS_MASK =
    (POS_BITS >= POS_W) ? {POS_W{1'b1}} : POS_W'((1 << POS_BITS) - 1);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_OUT  = 2'd2;

  localparam logic REG_CELL_SIZE = 1'b0;
  localparam logic REG_RANGE_H   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_INS_RD,
    ST_INS_WR,
    ST_Q_CELL,
    ST_Q_CNT,
    ST_Q_ENT,
    ST_Q_DRAIN,
    ST_Q_FIN
  } ugns_state_t;

endpackage
`default_nettype wire

// ===== design/ugns_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ugns_div import ugns_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [POS_W-1:0] num,
  input  wire logic [POS_W-1:0] den,
  output logic      [POS_W-1:0] quo,
  output logic                  done
);

  localparam int CW = $clog2(POS_W + 1);

  logic [POS_W:0]   rem;
  logic [POS_W-1:0] q;
  logic [POS_W-1:0] d;
  logic [CW-1:0]    cnt;
  logic             run;
  logic [POS_W:0]   trial;
  logic             ge;

  // restoring division, one quotient bit a cycle
  assign trial = {rem[POS_W-1:0], q[POS_W-1]};
  assign ge    = trial >= {1'b0, d};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(POS_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      q   <= num;
      d   <= den;
    end else if (run) begin
      rem <= ge ? (trial - {1'b0, d}) : trial;
      q   <= {q[POS_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ===== design/uniform_grid_neighbor_search_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Uniform-grid neighbour search. An item is taken when start is high and busy low; for an
// insert or a query busy then stays high until the item's results are out, and a clear
// does not raise busy. Results appear for one cycle each on res_valid and cannot be held
// off. The cell index is found by two 16-step serial dividers. A query then walks the
// 3x3 block: it steps past each cell outside the grid, reads the count of each in-grid
// cell and then does one store read per stored entry, drains the compare pipeline and
// ends with one final result. Clear works through per-cell valid bits.
module uniform_grid_neighbor_search_core import ugns_pkg::*; #(
  parameter int GRID_DIM = GRID_DIM_DEF,
  parameter int CELL_CAP = CELL_CAP_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       cmd,
  input  wire logic [POS_W-1:0] pos_x,
  input  wire logic [POS_W-1:0] pos_y,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [15:0]      cfg_data,
  output logic                  res_valid,
  output logic                  found,
  output logic      [POS_W-1:0] nbr_x,
  output logic      [POS_W-1:0] nbr_y,
  output logic                  last,
  output logic      [1:0]       status
);

  localparam int NCELLS   = GRID_DIM * GRID_DIM;
  localparam int CELL_W   = $clog2(NCELLS);
  localparam int ST_DEPTH = NCELLS * CELL_CAP;
  localparam int ST_AW    = $clog2(ST_DEPTH);
  localparam int GRID_W   = $clog2(GRID_DIM);

  ugns_state_t state, state_next;

  logic [15:0] grid_pitch, range_h;
  logic [31:0] r2;

  logic [1:0]       qcmd;
  logic [POS_W-1:0] qx, qy;
  logic [POS_W-1:0] cx, cy;
  logic             dx_done, dy_done, div_go;
  logic [POS_W-1:0] den;

  logic [1:0]        di, dj;
  logic [CELL_W-1:0] cell_q;
  logic [CNT_W-1:0]  e, n;

  // memories
  logic [CNT_W-1:0]   count_mem [NCELLS];
  logic [NCELLS-1:0]  cvalid;
  logic [CNT_W-1:0]   cnt_rd;
  logic               cnt_vld_rd;
  logic [2*POS_W-1:0] store_mem [ST_DEPTH];
  logic [2*POS_W-1:0] st_rd;

  // compare pipeline
  logic             d1_v, d2_v;
  logic [POS_W-1:0] s2x, s2y;
  logic [31:0]      dx2, dy2;
  logic [POS_W-1:0] ax, ay;
  logic             match;

  logic             pend_v;
  logic [POS_W-1:0] pend_x, pend_y;

  // control
  logic              accept;
  logic              in_grid_ins, cell_in_grid, last_cell, ent_end;
  logic [POS_W:0]    ii, jj, iim1, jjm1;
  logic [CELL_W-1:0] ins_cell, q_cell;
  logic [CNT_W-1:0]  cnt_eff, cnt_cap;
  logic [ST_AW-1:0]  st_addr, st_wr_addr;
  logic              cnt_rd_en, st_rd_en, cnt_we, clear_all, adv_cell, load_cell;
  logic              emit, emit_found, emit_last, pend_load;
  logic [POS_W-1:0]  emit_x, emit_y;
  logic [1:0]        emit_status;

  assign busy      = state != ST_IDLE;
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign div_go    = accept && (cmd == CMD_INSERT || cmd == CMD_QUERY);
  assign den       = (grid_pitch == '0) ? POS_W'(1) : grid_pitch;

  ugns_div u_div_x (
    .clk(clk), .rst(rst), .go(div_go), .num(pos_x & POS_MASK), .den(den),
    .quo(cx), .done(dx_done)
  );
  ugns_div u_div_y (
    .clk(clk), .rst(rst), .go(div_go), .num(pos_y & POS_MASK), .den(den),
    .quo(cy), .done(dy_done)
  );

  assign in_grid_ins = (cx < POS_W'(GRID_DIM)) && (cy < POS_W'(GRID_DIM));
  assign ins_cell    = CELL_W'(CELL_W'(cx[GRID_W-1:0]) * CELL_W'(GRID_DIM)
                       + CELL_W'(cy[GRID_W-1:0]));

  // neighbour cell, offset by one so the left and lower edges stay unsigned
  assign ii           = {1'b0, cx} + (POS_W+1)'(di);
  assign jj           = {1'b0, cy} + (POS_W+1)'(dj);
  assign iim1         = ii - (POS_W+1)'(1);
  assign jjm1         = jj - (POS_W+1)'(1);
  assign cell_in_grid = (ii != '0) && (ii <= (POS_W+1)'(GRID_DIM))
                        && (jj != '0) && (jj <= (POS_W+1)'(GRID_DIM));
  assign q_cell       = CELL_W'(CELL_W'(iim1[GRID_W-1:0]) * CELL_W'(GRID_DIM)
                        + CELL_W'(jjm1[GRID_W-1:0]));
  assign last_cell    = (di == 2'd2) && (dj == 2'd2);

  assign cnt_eff    = cnt_vld_rd ? cnt_rd : '0;
  assign cnt_cap    = (cnt_eff > CNT_W'(CELL_CAP)) ? CNT_W'(CELL_CAP) : cnt_eff;
  assign ent_end    = e == n - CNT_W'(1);
  assign st_addr    = ST_AW'(ST_AW'(cell_q) * ST_AW'(CELL_CAP) + ST_AW'(e));
  assign st_wr_addr = ST_AW'(ST_AW'(cell_q) * ST_AW'(CELL_CAP) + ST_AW'(cnt_eff));

  // compare stage: dx^2 + dy^2 <= r^2, kept exact in 33 bits
  assign ax    = (st_rd[POS_W-1:0] > qx) ? st_rd[POS_W-1:0] - qx : qx - st_rd[POS_W-1:0];
  assign ay    = (st_rd[2*POS_W-1:POS_W] > qy) ? st_rd[2*POS_W-1:POS_W] - qy
                                                : qy - st_rd[2*POS_W-1:POS_W];
  assign match = d2_v && (({1'b0, dx2} + {1'b0, dy2}) <= {1'b0, r2});

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (div_go) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (dx_done && dy_done) state_next = (qcmd == CMD_INSERT) ? ST_INS_RD : ST_Q_CELL;
      end
      ST_INS_RD:  state_next = in_grid_ins ? ST_INS_WR : ST_IDLE;
      ST_INS_WR:  state_next = ST_IDLE;
      ST_Q_CELL: begin
        if (cell_in_grid) state_next = ST_Q_CNT;
        else if (last_cell) state_next = ST_Q_DRAIN;
      end
      ST_Q_CNT: begin
        if (cnt_cap != '0) state_next = ST_Q_ENT;
        else state_next = last_cell ? ST_Q_DRAIN : ST_Q_CELL;
      end
      ST_Q_ENT: begin
        if (ent_end) state_next = last_cell ? ST_Q_DRAIN : ST_Q_CELL;
      end
      ST_Q_DRAIN: begin
        if (!d1_v && !d2_v) state_next = ST_Q_FIN;
      end
      ST_Q_FIN:   state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_rd_en   = 1'b0;
    st_rd_en    = 1'b0;
    cnt_we      = 1'b0;
    clear_all   = 1'b0;
    adv_cell    = 1'b0;
    load_cell   = 1'b0;
    emit        = 1'b0;
    emit_found  = 1'b0;
    emit_last   = 1'b1;
    emit_x      = '0;
    emit_y      = '0;
    emit_status = STAT_OK;
    pend_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && !div_go) begin
          emit      = 1'b1;
          clear_all = cmd == CMD_CLEAR;
        end
      end
      ST_INS_RD: begin
        if (in_grid_ins) begin
          cnt_rd_en = 1'b1;
          load_cell = 1'b1;
        end else begin
          emit        = 1'b1;
          emit_status = STAT_OUT;
        end
      end
      ST_INS_WR: begin
        emit = 1'b1;
        if (cnt_eff >= CNT_W'(CELL_CAP)) emit_status = STAT_FULL;
        else cnt_we = 1'b1;
      end
      ST_Q_CELL: begin
        if (cell_in_grid) begin
          cnt_rd_en = 1'b1;
          load_cell = 1'b1;
        end else begin
          adv_cell = 1'b1;
        end
      end
      ST_Q_CNT: begin
        if (cnt_cap == '0) adv_cell = 1'b1;
      end
      ST_Q_ENT: begin
        st_rd_en = 1'b1;
        adv_cell = ent_end;
      end
      ST_Q_FIN: begin
        emit       = 1'b1;
        emit_found = pend_v;
        emit_x     = pend_v ? pend_x : '0;
        emit_y     = pend_v ? pend_y : '0;
      end
      default: ;
    endcase
    // a hit goes out only once the next one shows it was not the last
    if (match) begin
      pend_load = 1'b1;
      if (pend_v) begin
        emit       = 1'b1;
        emit_found = 1'b1;
        emit_last  = 1'b0;
        emit_x     = pend_x;
        emit_y     = pend_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      grid_pitch <= 16'd4096;
      range_h    <= 16'd4096;
      cvalid     <= '0;
      res_valid  <= 1'b0;
      d1_v       <= 1'b0;
      d2_v       <= 1'b0;
      pend_v     <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= emit;
      d1_v      <= st_rd_en;
      d2_v      <= d1_v;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CELL_SIZE) grid_pitch <= cfg_data;
        if (cfg_index == REG_RANGE_H) range_h <= cfg_data;
      end
      if (clear_all) cvalid <= '0;
      else if (cnt_we) cvalid[cell_q] <= 1'b1;
      if (pend_load) pend_v <= 1'b1;
      else if (state == ST_Q_FIN) pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    r2 <= range_h * range_h;
    if (accept) begin
      qcmd <= cmd;
      qx   <= pos_x & POS_MASK;
      qy   <= pos_y & POS_MASK;
    end
    if (state == ST_DIV) begin
      di <= '0;
      dj <= '0;
    end else if (adv_cell) begin
      if (dj == 2'd2) begin
        dj <= '0;
        di <= di + 2'd1;
      end else begin
        dj <= dj + 2'd1;
      end
    end
    if (load_cell) cell_q <= (state == ST_INS_RD) ? ins_cell : q_cell;
    if (state == ST_Q_CNT) begin
      n <= cnt_cap;
      e <= '0;
    end else if (st_rd_en) begin
      e <= e + CNT_W'(1);
    end
    if (cnt_rd_en) begin
      cnt_rd     <= count_mem[(state == ST_INS_RD) ? ins_cell : q_cell];
      cnt_vld_rd <= cvalid[(state == ST_INS_RD) ? ins_cell : q_cell];
    end
    if (cnt_we) begin
      count_mem[cell_q]     <= cnt_eff + CNT_W'(1);
      store_mem[st_wr_addr] <= {qy, qx};
    end
    if (st_rd_en) st_rd <= store_mem[st_addr];
    dx2 <= ax * ax;
    dy2 <= ay * ay;
    s2x <= st_rd[POS_W-1:0];
    s2y <= st_rd[2*POS_W-1:POS_W];
    if (pend_load) begin
      pend_x <= s2x;
      pend_y <= s2y;
    end
    if (emit) begin
      found  <= emit_found;
      nbr_x  <= emit_x;
      nbr_y  <= emit_y;
      last   <= emit_last;
      status <= emit_status;
    end
  end

endmodule
`default_nettype wire
